/* src/prt_pkg.sv */
// package for the position ramp track: sizes, ring entry type, status codes
// no dependencies
`default_nettype none
package prt_pkg;
  localparam int RING_DEPTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int DCNT_W     = $clog2(FRAC_BITS + 1);
  localparam int PROD_W     = 17 + FRAC_BITS + 1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERLAP  = 2'd1;
  localparam logic [1:0] ST_BACKWARD = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef logic [2:0][15:0] vec3_t;

  typedef struct packed {
    logic [47:0] start;
    logic [23:0] len;
    vec3_t       origin;
    vec3_t       target;
  } entry_t;
endpackage
`default_nettype wire

/* src/prt_if.sv */
// request and response channels of the position ramp track
// depends on nothing
`default_nettype none
interface prt_req_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic        [47:0] event_sample;
  logic        [23:0] ramp_length;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic signed [15:0] target_z;
  modport source (output valid, mode, event_sample, ramp_length, target_x, target_y, target_z,
                  input ready);
  modport sink (input valid, mode, event_sample, ramp_length, target_x, target_y, target_z,
                output ready);
endinterface

interface prt_rsp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  modport source (output valid, status, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, status, pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

/* src/prt_ring.sv */
// ramp ring storage: one write port, one registered read port
// depends on prt_pkg
`default_nettype none
module prt_ring
  import prt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [PTR_W-1:0] waddr,
  input  wire entry_t           wdata,
  input  wire logic [PTR_W-1:0] raddr,
  output entry_t                rdata
);
  entry_t mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/position_ramp_track_top.sv */
// position ramp track top: sequencer, shared divider step and multiplier
// depends on prt_pkg, prt_if, prt_ring
//
// usage: req carries one transaction per item (mode 0 append a ramp, mode 1
// query a sample); rsp returns one transaction per item with status and
// position. req.ready is high only while the sequencer is idle, so one item
// is in work at a time. cfg_we/cfg_index/cfg_data set the starting position
// (index 0..2 = x, y, z) and must only be written while idle.
// append reads the newest ring entry (S_ARD), checks it (S_ACHK) and loads
// the output register in S_FIN. a query checks the time (S_QCHK), then reads
// and evaluates the ring head (S_QRD, S_QEV), again for each retired ramp;
// while a ramp is in progress it then runs the restoring divider, one quotient
// bit per cycle, and the shared multiplier (a multiply and an accumulate step
// per axis). req.ready returns at the same edge that loads the result.
// reset clears the ring pointers, the last query time and the position to
// zero; ring entries need no clearing.
// a stalled receiver holds the result in the output register; a new item
// can still be accepted and is worked on, then waits to finish until the
// register is taken.
`default_nettype none
module position_ramp_track_top
  import prt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  prt_req_if.sink          req,
  prt_rsp_if.source        rsp
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ARD  = 4'd1;
  localparam logic [3:0] S_ACHK = 4'd2;
  localparam logic [3:0] S_QCHK = 4'd3;
  localparam logic [3:0] S_QRD  = 4'd4;
  localparam logic [3:0] S_QEV  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_ACC  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]       state;
  logic [PTR_W-1:0] ring_head;
  logic [CNT_W-1:0] ring_count;
  logic             newest_valid;
  vec3_t            last_target;
  vec3_t            held_position;
  logic [47:0]      last_query;

  logic [47:0]      t_r;
  logic [23:0]      len_r;
  vec3_t            tgt_r;

  logic [23:0]          rem;
  logic [FRAC_BITS-1:0] frac;
  logic [DCNT_W-1:0]    dcnt;
  logic [1:0]           ax;
  logic signed [PROD_W-1:0] prod;
  logic [1:0]           res_status;
  vec3_t                res_pos;

  entry_t           rd_q;
  entry_t           wdata;
  logic             we;
  logic [PTR_W-1:0] waddr;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] newest;
  logic [PTR_W-1:0] push_slot;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W+1:0] nsum;
  logic [PTR_W+1:0] psum;
  logic [48:0]      end49;
  logic             before_end;
  logic             before_start;
  logic             overlap;
  logic             replace;
  logic             full;
  logic [24:0]      r2;
  logic             ge;
  logic signed [16:0] diff;
  logic signed [PROD_W-1:0] mul_c;
  logic [15:0]      org_a;
  logic [15:0]      tgt_a;
  logic             rsp_free;

  prt_ring u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_q)
  );

  always_comb begin
    nsum = (PTR_W+2)'(ring_head) + (PTR_W+2)'(ring_count) + (PTR_W+2)'(RING_DEPTH - 1);
    if (nsum >= (PTR_W+2)'(2 * RING_DEPTH)) begin
      nsum = nsum - (PTR_W+2)'(2 * RING_DEPTH);
    end else if (nsum >= (PTR_W+2)'(RING_DEPTH)) begin
      nsum = nsum - (PTR_W+2)'(RING_DEPTH);
    end
    newest = nsum[PTR_W-1:0];
    psum = (PTR_W+2)'(ring_head) + (PTR_W+2)'(ring_count);
    if (psum >= (PTR_W+2)'(RING_DEPTH)) begin
      psum = psum - (PTR_W+2)'(RING_DEPTH);
    end
    push_slot = psum[PTR_W-1:0];
    if (ring_head == PTR_W'(RING_DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = ring_head + PTR_W'(1);
    end
    rd_addr = (state == S_ARD) ? newest : ring_head;

    end49        = {1'b0, rd_q.start} + 49'(rd_q.len);
    before_end   = {1'b0, t_r} < end49;
    before_start = t_r < rd_q.start;
    overlap      = newest_valid && before_end;
    replace      = newest_valid && (t_r == rd_q.start) && (rd_q.len == '0);
    full         = ring_count == CNT_W'(RING_DEPTH);

    we    = 1'b0;
    waddr = newest;
    wdata = '{start: t_r, len: len_r, origin: last_target, target: tgt_r};
    if (state == S_ACHK && !overlap) begin
      if (replace) begin
        we    = 1'b1;
        wdata = '{start: rd_q.start, len: len_r, origin: rd_q.origin, target: tgt_r};
      end else if (!full) begin
        we    = 1'b1;
        waddr = push_slot;
      end
    end

    r2 = {rem, 1'b0};
    ge = r2 >= {1'b0, rd_q.len};

    org_a = rd_q.origin[ax];
    tgt_a = rd_q.target[ax];
    diff  = $signed({tgt_a[15], tgt_a}) - $signed({org_a[15], org_a});
    mul_c = PROD_W'(diff) * PROD_W'($signed({1'b0, frac}));

    rsp_free = !rsp.valid || rsp.ready;
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ring_head     <= '0;
      ring_count    <= '0;
      newest_valid  <= 1'b0;
      last_target   <= '0;
      held_position <= '0;
      last_query    <= '0;
      rsp.valid     <= 1'b0;
    end else begin
      if (state == S_FIN && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (cfg_we && cfg_index != 2'd3) begin
        last_target[cfg_index]   <= cfg_data;
        held_position[cfg_index] <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            t_r      <= req.event_sample;
            len_r    <= req.ramp_length;
            tgt_r    <= {req.target_z, req.target_y, req.target_x};
            res_pos  <= '0;
            state    <= (req.mode == MODE_QUERY) ? S_QCHK : S_ARD;
          end
        end
        S_ARD: begin
          state <= S_ACHK;
        end
        S_ACHK: begin
          if (overlap) begin
            res_status <= ST_OVERLAP;
          end else if (replace) begin
            res_status  <= ST_OK;
            last_target <= tgt_r;
          end else if (full) begin
            res_status <= ST_FULL;
          end else begin
            res_status   <= ST_OK;
            last_target  <= tgt_r;
            ring_count   <= ring_count + CNT_W'(1);
            newest_valid <= 1'b1;
          end
          state <= S_FIN;
        end
        S_QCHK: begin
          if (t_r < last_query) begin
            res_status <= ST_BACKWARD;
            state      <= S_FIN;
          end else begin
            res_status <= ST_OK;
            last_query <= t_r;
            state      <= S_QRD;
          end
        end
        S_QRD: begin
          state <= S_QEV;
        end
        S_QEV: begin
          if (ring_count == '0 || (before_end && before_start)) begin
            res_pos <= held_position;
            state   <= S_FIN;
          end else if (!before_end) begin
            held_position <= rd_q.target;
            ring_head     <= head_inc;
            ring_count    <= ring_count - CNT_W'(1);
            state         <= S_QRD;
          end else if (rd_q.len == '0) begin
            res_pos <= rd_q.target;
            state   <= S_FIN;
          end else begin
            rem   <= 24'(t_r - rd_q.start);
            frac  <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= ge ? 24'(r2 - {1'b0, rd_q.len}) : r2[23:0];
          frac <= {frac[FRAC_BITS-2:0], ge};
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_W'(FRAC_BITS - 1)) begin
            ax    <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= mul_c;
          state <= S_ACC;
        end
        S_ACC: begin
          res_pos[ax] <= org_a + prod[FRAC_BITS +: 16];
          if (ax == 2'd2) begin
            state <= S_FIN;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_MUL;
          end
        end
        S_FIN: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && rsp_free) begin
      rsp.status <= res_status;
      rsp.pos_x  <= res_pos[0];
      rsp.pos_y  <= res_pos[1];
      rsp.pos_z  <= res_pos[2];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= CNT_W'(RING_DEPTH))
    else $error("ring count above depth");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.pos_x == '0 && rsp.pos_y == '0 && rsp.pos_z == '0)
    else $error("error transaction with nonzero position");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && rsp.valid && !rsp.ready |=> state == S_FIN)
    else $error("result overwrote a pending transaction");

  a_retire: assert property (@(posedge clk) disable iff (rst)
    state == S_QEV && ring_count != '0 && !before_end |=>
      ring_count == $past(ring_count) - CNT_W'(1) && state == S_QRD)
    else $error("retire did not drop one ramp");
endmodule
`default_nettype wire

/* test/tb_position_ramp_track_top.sv */
// testbench for position_ramp_track_top: directed and random append and query items,
// checked against an in-bench predictor of the ramp ring
// depends on prt_pkg, prt_if and the rtl of position_ramp_track_top
`default_nettype none
module tb_position_ramp_track_top;
  import prt_pkg::*;

  typedef struct {
    logic [1:0]         status;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } track_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  prt_req_if req ();
  prt_rsp_if rsp ();

  position_ramp_track_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req.sink), .rsp(rsp.source)
  );

  always #6 clk = ~clk;

  // predicted ring state
  logic [47:0]        ring_start [RING_DEPTH];
  logic [23:0]        ring_len   [RING_DEPTH];
  logic signed [15:0] ring_org   [RING_DEPTH][3];
  logic signed [15:0] ring_tgt   [RING_DEPTH][3];
  int                 head_idx, live_count;
  bit                 any_ramp;
  logic signed [15:0] last_tgt [3];
  logic signed [15:0] held_pos [3];
  logic [47:0]        last_query_t;

  track_result_t expected_positions [$];
  int  error_count = 0;
  int  item_count = 0;
  int  result_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  longint cycle_count = 0;

  function automatic logic [48:0] newest_end();
    int n;
    n = (head_idx + live_count + RING_DEPTH - 1) % RING_DEPTH;
    return {1'b0, ring_start[n]} + ring_len[n];
  endfunction

  function automatic logic signed [15:0] lerp(logic signed [15:0] org, logic signed [15:0] tgt,
                                              longint frac);
    longint prod;
    prod = (longint'(tgt) - longint'(org)) * frac;
    return org + 16'(prod >>> FRAC_BITS);
  endfunction

  function automatic track_result_t predict_position(logic mode, logic [47:0] t,
                                                     logic [23:0] len,
                                                     logic signed [15:0] tg [3]);
    track_result_t r;
    int n, slot;
    bit replace;
    longint unsigned el, frac;
    r.status = ST_OK;
    r.x = '0; r.y = '0; r.z = '0;
    if (mode == MODE_APPEND) begin
      n = (head_idx + live_count + RING_DEPTH - 1) % RING_DEPTH;
      replace = 1'b0;
      if (any_ramp) begin
        if ({1'b0, t} < newest_end()) r.status = ST_OVERLAP;
        else if (t == ring_start[n] && ring_len[n] == 0) replace = 1'b1;
      end
      if (r.status == ST_OK) begin
        if (replace) begin
          ring_len[n] = len;
          for (int a = 0; a < 3; a++) ring_tgt[n][a] = tg[a];
        end else if (live_count >= RING_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = (head_idx + live_count) % RING_DEPTH;
          ring_start[slot] = t;
          ring_len[slot] = len;
          for (int a = 0; a < 3; a++) begin
            ring_org[slot][a] = last_tgt[a];
            ring_tgt[slot][a] = tg[a];
          end
          live_count++;
          any_ramp = 1'b1;
        end
        if (r.status == ST_OK) for (int a = 0; a < 3; a++) last_tgt[a] = tg[a];
      end
    end else if (t < last_query_t) begin
      r.status = ST_BACKWARD;
    end else begin
      last_query_t = t;
      while (live_count > 0 && {1'b0, t} >= {1'b0, ring_start[head_idx]} + ring_len[head_idx]) begin
        for (int a = 0; a < 3; a++) held_pos[a] = ring_tgt[head_idx][a];
        head_idx = (head_idx + 1) % RING_DEPTH;
        live_count--;
      end
      if (live_count == 0 || t < ring_start[head_idx]) begin
        r.x = held_pos[0]; r.y = held_pos[1]; r.z = held_pos[2];
      end else if (ring_len[head_idx] == 0) begin
        r.x = ring_tgt[head_idx][0]; r.y = ring_tgt[head_idx][1]; r.z = ring_tgt[head_idx][2];
      end else begin
        el = t - ring_start[head_idx];
        frac = (el << FRAC_BITS) / ring_len[head_idx];
        r.x = lerp(ring_org[head_idx][0], ring_tgt[head_idx][0], frac);
        r.y = lerp(ring_org[head_idx][1], ring_tgt[head_idx][1], frac);
        r.z = lerp(ring_org[head_idx][2], ring_tgt[head_idx][2], frac);
      end
    end
    return r;
  endfunction

  task automatic send_item(logic mode, logic [47:0] t, logic [23:0] len,
                           logic signed [15:0] tx, logic signed [15:0] ty,
                           logic signed [15:0] tz);
    logic signed [15:0] tg [3];
    tg[0] = tx; tg[1] = ty; tg[2] = tz;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode <= mode;
    req.event_sample <= t;
    req.ramp_length <= len;
    req.target_x <= tx;
    req.target_y <= ty;
    req.target_z <= tz;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_positions.insert(expected_positions.size(), predict_position(mode, t, len, tg));
    item_count++;
  endtask

  task automatic append(logic [47:0] t, logic [23:0] len, logic signed [15:0] tx,
                        logic signed [15:0] ty, logic signed [15:0] tz);
    send_item(MODE_APPEND, t, len, tx, ty, tz);
  endtask

  task automatic query(logic [47:0] t);
    send_item(MODE_QUERY, t, 24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_start(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    logic signed [15:0] v [3];
    v[0] = x; v[1] = y; v[2] = z;
    wait_idle();
    for (int a = 0; a < 3; a++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(a);
      cfg_data <= v[a];
      @(posedge clk);
      last_tgt[a] = v[a];
      held_pos[a] = v[a];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    track_result_t e;
    cycle_count <= cycle_count + 1;
    if (!rst && rsp.valid && rsp.ready) begin
      result_count++;
      if (expected_positions.size() == 0) begin
        $display("%0t: unexpected result status=%0d pos=%0d,%0d,%0d", $time,
                 rsp.status, rsp.pos_x, rsp.pos_y, rsp.pos_z);
        error_count++;
      end else begin
        e = expected_positions.pop_front();
        if (rsp.status !== e.status || rsp.pos_x !== e.x || rsp.pos_y !== e.y ||
            rsp.pos_z !== e.z) begin
          $display("%0t: mismatch expected status=%0d pos=%0d,%0d,%0d actual status=%0d pos=%0d,%0d,%0d",
                   $time, e.status, e.x, e.y, e.z, rsp.status, rsp.pos_x, rsp.pos_y, rsp.pos_z);
          error_count++;
        end
      end
    end
    rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (cycle_count > 64'd4000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    query(48'd0);
    append(48'd100, 24'd0, 16'sh7fff, -16'sh8000, 16'sd0);
    query(48'd50);
    query(48'd100);
    append(48'd200, 24'd0, 16'sd1000, 16'sd2000, 16'sd3000);
    append(48'd200, 24'd100, -16'sh8000, 16'sh7fff, -16'sd1);
    query(48'd250);
    query(48'd150);
    append(48'd250, 24'd10, 16'sd0, 16'sd0, 16'sd0);
    query(48'd299);
    query(48'd300);
    append(48'd400, 24'd0, 16'sd5, 16'sd6, 16'sd7);
    query(48'd400);
    append(48'd400, 24'd50, 16'sd9, 16'sd9, 16'sd9);
    query(48'd420);
    append(48'd450, 24'hffffff, 16'sh7fff, 16'sh7fff, -16'sh8000);
    query(48'd450 + 48'h7fffff);
    query(48'd450 + 48'hfffffe);
    query(48'd450 + 48'hffffff);
  endtask

  task automatic test_ring_full();
    logic [47:0] t;
    t = last_query_t + 48'd1000;
    for (int i = 0; i < RING_DEPTH + 2; i++)
      append(t + 48'(i * 20), 24'd20, 16'($urandom), 16'($urandom), 16'($urandom));
    query(t + 48'd5);
    append(t + 48'd2000, 24'd3, 16'sd1, 16'sd2, 16'sd3);
    query(t + 48'd5000);
  endtask

  task automatic test_random(int n, int send_pct, int recv_pct, logic [47:0] jump);
    logic [48:0] e;
    logic [47:0] t;
    int r;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    query(last_query_t + jump + 48'({$urandom, $urandom}) % (jump + 48'd1));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      e = any_ramp ? newest_end() : 49'd0;
      if (e < {1'b0, last_query_t}) e = {1'b0, last_query_t};
      if (r < 45) begin
        if (e[48]) e = 49'h0ffff_ffff_fff0;
        t = 48'(e) + (($urandom_range(3) == 0) ? 48'd0 : 48'($urandom_range(200)));
        case ($urandom_range(9))
          0, 1: append(t, 24'd0, 16'($urandom), 16'($urandom), 16'($urandom));
          2: append(t, 24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
          default: append(t, 24'($urandom_range(1, 300)), 16'($urandom), 16'($urandom),
                          16'($urandom));
        endcase
      end else if (r < 88) begin
        query(last_query_t + 48'($urandom_range(0, 250)));
      end else if (r < 94 && any_ramp && e > 0) begin
        append(48'({$urandom, $urandom} % e), 24'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom));
      end else begin
        query((last_query_t == 0) ? 48'd0 : 48'({$urandom, $urandom}) % last_query_t);
      end
    end
  endtask

  task automatic test_top_of_time();
    append(48'hffff_ffff_fff0, 24'hffffff, 16'sh7fff, -16'sh8000, 16'sh1234);
    append(48'hffff_ffff_fff8, 24'd1, 16'sd0, 16'sd0, 16'sd0);
    query(48'hffff_ffff_fff0);
    query(48'hffff_ffff_ffff);
    query(48'hffff_ffff_fffe);
  endtask

  initial begin
    req.valid = 1'b0;
    req.mode = MODE_APPEND;
    req.event_sample = '0;
    req.ramp_length = '0;
    req.target_x = '0;
    req.target_y = '0;
    req.target_z = '0;
    rsp.ready = 1'b0;
    head_idx = 0;
    live_count = 0;
    any_ramp = 1'b0;
    last_query_t = '0;
    for (int a = 0; a < 3; a++) begin
      last_tgt[a] = '0;
      held_pos[a] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 9;
    recv_idle_pct = 66;
    test_directed();
    write_start(16'sh7fff, -16'sh8000, 16'sd0);
    test_ring_full();
    test_random(330, 9, 66, 48'h0000_0100_0000);
    write_start(-16'sh8000, 16'sh7fff, -16'sh8000);
    test_random(330, 66, 9, 48'h0100_0000_0000);
    write_start(16'($urandom), 16'($urandom), 16'($urandom));
    test_random(330, 0, 0, 48'h3fff_0000_0000);
    query(48'h8000_0000_0000 | 48'($urandom));
    write_start(16'sd0, 16'sh7fff, -16'sd1);
    test_top_of_time();
    wait_idle();

    $display("covered %0d items (%0d results) across three idle patterns,", item_count,
             result_count);
    $display("start position writes, ring full, overlap, jumps and backward queries");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
